// ===== rtl/acpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acpe_pkg: shared types and constants of the AABB collision pair engine
// Holds the item codes, the slot table entry layout, the controller state
// type, the command and status groups and the notify matrix lookup.
// ---------------------------------------------------------------------------
package acpe_pkg;

    // Input item kinds, carried on tuser.
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result kinds, carried on tuser.
    localparam logic [2:0] RES_ADDED     = 3'd0;
    localparam logic [2:0] RES_FULL      = 3'd1;
    localparam logic [2:0] RES_MARKED    = 3'd2;
    localparam logic [2:0] RES_MISSED    = 3'd3;
    localparam logic [2:0] RES_PAIR      = 3'd4;
    localparam logic [2:0] RES_TICK_DONE = 3'd5;

    localparam int MATRIX_W = 36;
    localparam int NUM_TYPES = 6;
    localparam logic [MATRIX_W-1:0] MATRIX_RESET = 36'd16114649104;

    // Slot table entry, one word of the table memory.
    typedef struct packed {
        logic        listener;
        logic [2:0]  kind;
        logic [14:0] height;
        logic [14:0] width;
        logic [15:0] top;
        logic [15:0] left;
    } t_acpe_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAIR,
        ST_DONE
    } t_acpe_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // input transaction completes this cycle
        logic pair_step;  // move on to the next slot pair
        logic emit_pair;  // load the current pair into the output register
        logic emit_done;  // load the tick done result
    } t_acpe_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_ready;  // the output register can take a result this cycle
        logic pair_hit;   // the current pair yields a collision result
        logic pair_last;  // the current pair is the final one of the walk
    } t_acpe_stat;

    // True when a collider of type row is told about a collider of type col.
    function automatic logic told(input logic [MATRIX_W-1:0] matrix,
                                  input logic [2:0] row, input logic [2:0] col);
        logic [5:0] idx;
        idx = 6'(row) * 6'd6 + 6'(col);
        if (row >= 3'(NUM_TYPES) || col >= 3'(NUM_TYPES)) begin
            return 1'b0;
        end
        return matrix[idx];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aabb_collision_pair_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aabb_collision_pair_engine: table of rectangle colliders with pair search
// Adds and erases colliders and, on a tick, reports every overlapping pair
// of occupied slots that the notify matrix allows, followed by a done result.
// ---------------------------------------------------------------------------
// An add or an erase transaction has a single result, which is loaded into
// the output register in its accept cycle; an input transaction is accepted
// while the controller is idle and the output register is empty or is being
// drained. A tick is accepted and purges the marked slots, then walks the
// NUM_SLOTS*(NUM_SLOTS-1)/2 slot pairs, one pair per cycle unless a stall
// holds the walk, then emits the done result: 28 pairs for eight slots. The
// two read ports of the slot table memory deliver both rectangles of a pair
// together. A pair that yields a result, and the done result, wait while the
// output register is still full, so a slow consumer stalls the tick.
// The slot table needs no clearing pass after reset: a slot's data is only
// used once an add has written it, and occupancy lives in flip-flops that
// reset clears. The notify matrix is written through the configuration
// channel, which is always ready; write it only while the block is idle.
// ---------------------------------------------------------------------------
module aabb_collision_pair_engine #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tdata from bit 0: pos_x[15:0], pos_y[31:16], size_w[46:32],
    // size_h[61:47], body_type[64:62], has_listener[65],
    // target_slot[68:66], zero fill[71:69].
    input  wire logic [71:0] i_s_tdata,
    // tuser: kind[1:0].
    input  wire logic [1:0]  i_s_tuser,
    // Result items.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata from bit 0: slot_a[2:0], slot_b[5:3], notify_a[6], notify_b[7].
    output logic [7:0]       o_m_tdata,
    // tuser: result_kind[2:0].
    output logic [2:0]       o_m_tuser,
    output logic             o_m_tlast,
    // Configuration: notify matrix write.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [35:0] i_cfg_data
);
    import acpe_pkg::*;

    t_acpe_cmd  cmd;
    t_acpe_stat stat;

    logic [2:0] slot_a;
    logic [2:0] slot_b;
    logic       notify_a;
    logic       notify_b;

    // The matrix register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    acpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    acpe_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_s_tuser),
        .i_pos_x         (i_s_tdata[15:0]),
        .i_pos_y         (i_s_tdata[31:16]),
        .i_size_w        (i_s_tdata[46:32]),
        .i_size_h        (i_s_tdata[61:47]),
        .i_body_type     (i_s_tdata[64:62]),
        .i_has_listener  (i_s_tdata[65]),
        .i_target_slot   (i_s_tdata[68:66]),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_m_tready      (i_m_tready),
        .o_stat          (stat),
        .o_m_tvalid      (o_m_tvalid),
        .o_result_kind   (o_m_tuser),
        .o_slot_a        (slot_a),
        .o_slot_b        (slot_b),
        .o_notify_a      (notify_a),
        .o_notify_b      (notify_b),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {notify_b, notify_a, slot_b, slot_a};

endmodule
`default_nettype wire

// ===== rtl/acpe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acpe_ram: generic RAM, one write port and two registered read ports
// Read data is registered and appears in the cycle after the read address is presented.
// ---------------------------------------------------------------------------
module acpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

// ===== rtl/acpe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acpe_ctrl: controller of the AABB collision pair engine
// Sequences input transactions, the pair walk of a tick and the done result.
// ---------------------------------------------------------------------------
module acpe_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic [1:0]          i_kind,
    input  wire acpe_pkg::t_acpe_stat i_stat,
    output logic                     o_s_tready,
    output acpe_pkg::t_acpe_cmd      o_cmd
);
    import acpe_pkg::*;

    t_acpe_state r_state;
    t_acpe_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // Add and erase finish in the accept cycle, so an item is only
                // taken when its result has a place to go.
                o_s_tready   = i_stat.out_ready;
                o_cmd.accept = i_s_tvalid && i_stat.out_ready;
                if (o_cmd.accept && i_kind == KIND_TICK) begin
                    n_state = ST_PAIR;
                end
            end
            ST_PAIR: begin
                if (!i_stat.pair_hit || i_stat.out_ready) begin
                    o_cmd.pair_step = 1'b1;
                    o_cmd.emit_pair = i_stat.pair_hit;
                    if (i_stat.pair_last) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_stat.out_ready) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/acpe_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// acpe_dpath: datapath of the AABB collision pair engine
// Slot table, occupancy bits, pair counters, overlap test, notify matrix
// and the output register.
// ---------------------------------------------------------------------------
module acpe_dpath #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire acpe_pkg::t_acpe_cmd               i_cmd,
    input  wire logic [1:0]                        i_kind,
    input  wire logic [15:0]                       i_pos_x,
    input  wire logic [15:0]                       i_pos_y,
    input  wire logic [14:0]                       i_size_w,
    input  wire logic [14:0]                       i_size_h,
    input  wire logic [2:0]                        i_body_type,
    input  wire logic                              i_has_listener,
    input  wire logic [2:0]                        i_target_slot,
    input  wire logic                              i_cfg_valid,
    input  wire logic [acpe_pkg::MATRIX_W-1:0]     i_cfg_data,
    input  wire logic                              i_m_tready,
    output acpe_pkg::t_acpe_stat                   o_stat,
    output logic                                   o_m_tvalid,
    output logic [2:0]                             o_result_kind,
    output logic [2:0]                             o_slot_a,
    output logic [2:0]                             o_slot_b,
    output logic                                   o_notify_a,
    output logic                                   o_notify_b,
    output logic                                   o_last
);
    import acpe_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EW = $bits(t_acpe_entry);

    logic [NUM_SLOTS-1:0] r_used;
    logic [NUM_SLOTS-1:0] n_used;
    logic [NUM_SLOTS-1:0] r_marked;
    logic [NUM_SLOTS-1:0] n_marked;
    logic [MATRIX_W-1:0]  r_matrix;

    logic [IW-1:0] r_i;
    logic [IW-1:0] n_i;
    logic [IW-1:0] r_k;
    logic [IW-1:0] n_k;

    logic          r_ovalid;
    logic [2:0]    r_okind;
    logic [2:0]    r_oa;
    logic [2:0]    r_ob;
    logic          r_ona;
    logic          r_onb;
    logic          r_olast;

    logic          out_ready;
    logic          do_add;
    logic          do_erase;
    logic          do_tick;
    logic          load;
    logic [2:0]    ld_kind;
    logic [2:0]    ld_a;
    logic [2:0]    ld_b;
    logic          ld_na;
    logic          ld_nb;
    logic          ld_last;

    logic          free_found;
    logic [IW-1:0] free_slot;
    logic          erase_ok;

    t_acpe_entry   wr_entry;
    logic [EW-1:0] rd_a;
    logic [EW-1:0] rd_b;
    t_acpe_entry   e_a;
    t_acpe_entry   e_b;

    logic signed [16:0] left_a;
    logic signed [16:0] right_a;
    logic signed [16:0] top_a;
    logic signed [16:0] bottom_a;
    logic signed [16:0] left_b;
    logic signed [16:0] right_b;
    logic signed [16:0] top_b;
    logic signed [16:0] bottom_b;
    logic               overlap;
    logic               told_ab;
    logic               told_ba;

    assign out_ready = !r_ovalid || i_m_tready;
    assign do_add    = i_cmd.accept && i_kind == KIND_ADD;
    assign do_erase  = i_cmd.accept && i_kind == KIND_ERASE;
    assign do_tick   = i_cmd.accept && i_kind == KIND_TICK;

    // Lowest free slot; marked slots still count as occupied.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                free_found = 1'b1;
                free_slot  = IW'(s);
            end
        end
    end

    assign erase_ok = ({1'b0, i_target_slot} < 4'(NUM_SLOTS))
                      && r_used[i_target_slot[IW-1:0]];

    always_comb begin
        n_used   = r_used;
        n_marked = r_marked;
        if (do_add && free_found) begin
            n_used[free_slot]   = 1'b1;
            n_marked[free_slot] = 1'b0;
        end else if (do_erase && erase_ok) begin
            n_marked[i_target_slot[IW-1:0]] = 1'b1;
        end else if (do_tick) begin
            // Purge: every marked slot is freed at once.
            n_used   = r_used & ~r_marked;
            n_marked = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_marked <= '0;
            r_matrix <= MATRIX_RESET;
        end else begin
            r_used   <= n_used;
            r_marked <= n_marked;
            if (i_cfg_valid) begin
                r_matrix <= i_cfg_data;
            end
        end
    end

    // Pair counters. The table is read at the next pair, so its registered
    // data belongs to the current pair; holding the counters holds the data.
    always_comb begin
        n_i = r_i;
        n_k = r_k;
        if (do_tick) begin
            n_i = '0;
            n_k = IW'(1);
        end else if (i_cmd.pair_step) begin
            if (r_k == IW'(NUM_SLOTS - 1)) begin
                n_i = IW'({1'b0, r_i} + (IW + 1)'(1));
                n_k = IW'({1'b0, r_i} + (IW + 1)'(2));
            end else begin
                n_k = IW'({1'b0, r_k} + (IW + 1)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_k <= n_k;
    end

    assign wr_entry = '{listener: i_has_listener, kind: i_body_type,
                        height: i_size_h, width: i_size_w,
                        top: i_pos_y, left: i_pos_x};

    acpe_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (do_add && free_found),
        .i_waddr   (free_slot),
        .i_wdata   (wr_entry),
        .i_raddr_a (n_i),
        .i_raddr_b (n_k),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign e_a = t_acpe_entry'(rd_a);
    assign e_b = t_acpe_entry'(rd_b);

    // Edges at 17 bits so that edge plus size cannot wrap.
    assign left_a   = $signed({e_a.left[15], e_a.left});
    assign top_a    = $signed({e_a.top[15], e_a.top});
    assign right_a  = left_a + $signed({2'b00, e_a.width});
    assign bottom_a = top_a + $signed({2'b00, e_a.height});
    assign left_b   = $signed({e_b.left[15], e_b.left});
    assign top_b    = $signed({e_b.top[15], e_b.top});
    assign right_b  = left_b + $signed({2'b00, e_b.width});
    assign bottom_b = top_b + $signed({2'b00, e_b.height});

    assign overlap = (left_a < right_b) && (right_a > left_b)
                     && (top_a < bottom_b) && (bottom_a > top_b);

    assign told_ab = told(r_matrix, e_a.kind, e_b.kind);
    assign told_ba = told(r_matrix, e_b.kind, e_a.kind);

    assign o_stat.out_ready = out_ready;
    assign o_stat.pair_hit  = r_used[r_i] && r_used[r_k] && overlap
                              && (told_ab || told_ba);
    assign o_stat.pair_last = (r_i == IW'(NUM_SLOTS - 2)) && (r_k == IW'(NUM_SLOTS - 1));

    // Result to load into the output register; unused fields are zero.
    always_comb begin
        load    = 1'b1;
        ld_kind = RES_TICK_DONE;
        ld_a    = '0;
        ld_b    = '0;
        ld_na   = 1'b0;
        ld_nb   = 1'b0;
        ld_last = 1'b1;
        priority if (do_add) begin
            ld_kind = free_found ? RES_ADDED : RES_FULL;
            ld_a    = free_found ? 3'(free_slot) : 3'd0;
        end else if (do_erase) begin
            ld_kind = erase_ok ? RES_MARKED : RES_MISSED;
            ld_a    = i_target_slot;
        end else if (i_cmd.emit_pair) begin
            ld_kind = RES_PAIR;
            ld_a    = 3'(r_i);
            ld_b    = 3'(r_k);
            ld_na   = told_ab && e_a.listener;
            ld_nb   = told_ba && e_b.listener;
            ld_last = 1'b0;
        end else if (i_cmd.emit_done) begin
            ld_kind = RES_TICK_DONE;
        end else begin
            load = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_okind <= ld_kind;
            r_oa    <= ld_a;
            r_ob    <= ld_b;
            r_ona   <= ld_na;
            r_onb   <= ld_nb;
            r_olast <= ld_last;
        end
    end

    assign o_m_tvalid    = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_slot_a      = r_oa;
    assign o_slot_b      = r_ob;
    assign o_notify_a    = r_ona;
    assign o_notify_b    = r_onb;
    assign o_last        = r_olast;

endmodule
`default_nettype wire
